FILE: src/jlrc_pkg.sv
// Package for the job lifecycle and retry controller.
// Holds state, opcode and fault codes, the transfer structs and the transition table.
// No dependencies.
package jlrc_pkg;

	typedef enum logic [2:0] {
		ST_PENDING  = 3'd0,
		ST_RUNNING  = 3'd1,
		ST_WAITING  = 3'd2,
		ST_SUCCESS  = 3'd3,
		ST_FAILURE  = 3'd4,
		ST_RETRYING = 3'd5,
		ST_ABORTING = 3'd6,
		ST_ABORTED  = 3'd7
	} job_state_t;

	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_CRANK    = 3'd1,
		OP_SHUTDOWN = 3'd2,
		OP_WAKE     = 3'd3,
		OP_TICK     = 3'd4,
		OP_ARM      = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		RR_SUCCESS = 3'd0,
		RR_FAILURE = 3'd1,
		RR_WAITING = 3'd2,
		RR_RUNNING = 3'd3,
		RR_ABORTED = 3'd4
	} run_result_t;

	typedef enum logic [2:0] {
		PS_RUNNING = 3'd0,
		PS_WAITING = 3'd1,
		PS_SUCCESS = 3'd2,
		PS_FAILURE = 3'd3,
		PS_ABORTED = 3'd4
	} public_state_t;

	typedef enum logic [1:0] {
		FLT_NONE        = 2'd0,
		FLT_ILLEGAL     = 2'd1,
		FLT_NOT_ALLOWED = 2'd2,
		FLT_WAIT_ARMED  = 2'd3
	} fault_t;

	localparam logic [7:0] MAX_RETRIES_RST = 8'd5;
	localparam logic [3:0] BACKOFF_SH_MAX  = 4'd8;

	// bit t of row f set: f -> t allowed
	localparam logic [7:0] LEGAL_NEXT [8] = '{
		8'h42, 8'h7E, 8'h42, 8'h01, 8'h01, 8'h04, 8'hC0, 8'h01
	};

	typedef struct packed {
		logic [2:0]  opcode;
		logic [2:0]  run_result;
		logic        abort_done;
		logic [15:0] wait_ticks;
		logic [8:0]  random_draw;
	} job_in_t;

	typedef struct packed {
		logic [2:0] job_state;
		logic [2:0] public_state;
		logic [7:0] retry_number;
		logic [9:0] retry_eta;
		logic       notify;
		logic [1:0] fault;
	} job_out_t;

	function automatic logic is_legal(input job_state_t from_st, input job_state_t to_st);
		logic [7:0] row;
		row = LEGAL_NEXT[from_st];
		return row[to_st];
	endfunction

endpackage

FILE: src/job_lifecycle_retry_controller_unit.sv
// Job lifecycle and retry controller, top level.
// Input register, single-pass command logic, result register.
// Depends on jlrc_pkg.

// Takes one command per cycle while the result side does not stall and returns one result per
// command: the command lands in an input register, is decoded against the held job state, the
// retry counter and the two timers in one pass, and the updated view leaves through a result
// register. Stalls on the result side back up through in_ready only when both registers are full.
// max_retries is written through cfg_we/cfg_wdata; the user must write it only while no command
// is in flight, as the block itself does not enforce this.
module job_lifecycle_retry_controller_unit
	import jlrc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  job_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output job_out_t out_data,
	input  logic     cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic       valid_s1;
	job_in_t    item_s1;
	logic       advance;

	logic [7:0] max_retries_q;
	job_state_t state_q;
	logic [7:0] retry_cnt_q;
	logic [9:0] retry_tmr_q;
	logic       retry_act_q;
	logic [15:0] wait_tmr_q;
	logic       wait_act_q;
	logic       out_valid_q;
	job_out_t   out_q;

	job_state_t state_d;
	logic [7:0] retry_cnt_d;
	logic [9:0] retry_tmr_d;
	logic       retry_act_d;
	logic [15:0] wait_tmr_d;
	logic       wait_act_d;
	fault_t     fault_d;
	logic       notify_d;
	job_out_t   res_d;

	job_state_t tgt;
	logic       done;
	logic [3:0] backoff_sh;
	logic [8:0] backoff_mask;
	logic [9:0] retry_load;
	logic       retry_fire;
	logic       wait_fire;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign done = (state_q == ST_SUCCESS) || (state_q == ST_FAILURE) ||
		(state_q == ST_ABORTED);
	assign backoff_sh = (retry_cnt_q > 8'(BACKOFF_SH_MAX)) ? BACKOFF_SH_MAX : retry_cnt_q[3:0];
	assign backoff_mask = 9'((10'd2 << backoff_sh) - 10'd1);
	assign retry_load = {1'b0, item_s1.random_draw & backoff_mask} + 10'd1;

	// crank target before the table check
	always_comb begin
		tgt = ST_SUCCESS;
		if (state_q == ST_ABORTING) begin
			tgt = item_s1.abort_done ? ST_ABORTED : ST_ABORTING;
		end else begin
			case (run_result_t'(item_s1.run_result))
				RR_SUCCESS: tgt = ST_SUCCESS;
				RR_FAILURE: tgt = ST_FAILURE;
				RR_WAITING: tgt = ST_WAITING;
				RR_RUNNING: tgt = ST_RUNNING;
				RR_ABORTED: tgt = ST_ABORTED;
				default:    tgt = ST_SUCCESS;
			endcase
			if (tgt == ST_FAILURE && retry_cnt_q < max_retries_q) begin
				tgt = ST_RETRYING;
			end
		end
	end

	// next state
	always_comb begin
		state_d     = state_q;
		retry_cnt_d = retry_cnt_q;
		retry_tmr_d = retry_tmr_q;
		retry_act_d = retry_act_q;
		wait_tmr_d  = wait_tmr_q;
		wait_act_d  = wait_act_q;
		fault_d     = FLT_NONE;
		notify_d    = 1'b0;
		retry_fire  = 1'b0;
		wait_fire   = 1'b0;
		unique case (item_s1.opcode)
			OP_START: begin
				if (state_q == ST_PENDING || is_legal(state_q, ST_PENDING)) begin
					state_d     = ST_RUNNING;
					retry_cnt_d = '0;
					retry_tmr_d = '0;
					retry_act_d = 1'b0;
				end else begin
					fault_d = FLT_ILLEGAL;
				end
			end
			OP_CRANK: begin
				if (done || state_q == ST_WAITING) begin
					fault_d = FLT_NOT_ALLOWED;
				end else if (state_q != ST_ABORTING && item_s1.run_result > RR_ABORTED) begin
					fault_d = FLT_NOT_ALLOWED;
				end else if (!is_legal(state_q, tgt)) begin
					fault_d = FLT_ILLEGAL;
				end else begin
					if (state_q == ST_PENDING && tgt == ST_RUNNING) begin
						retry_cnt_d = '0;
						retry_tmr_d = '0;
						retry_act_d = 1'b0;
					end
					if (tgt == ST_FAILURE || tgt == ST_RETRYING || tgt == ST_ABORTED) begin
						retry_tmr_d = '0;
						retry_act_d = 1'b0;
					end
					state_d = tgt;
					if (tgt == ST_RETRYING) begin
						retry_tmr_d = retry_load;
						retry_act_d = 1'b1;
						state_d     = ST_WAITING;
					end
				end
			end
			OP_SHUTDOWN: begin
				if (!done) begin
					wait_tmr_d = '0;
					wait_act_d = 1'b0;
					if (is_legal(state_q, ST_ABORTING)) begin
						state_d = ST_ABORTING;
					end else begin
						fault_d = FLT_ILLEGAL;
					end
				end
			end
			OP_WAKE: begin
				if (state_q == ST_WAITING) begin
					state_d    = ST_RUNNING;
					wait_tmr_d = '0;
					wait_act_d = 1'b0;
					notify_d   = 1'b1;
				end
			end
			OP_TICK: begin
				if (retry_act_q && retry_tmr_q != '0) begin
					retry_tmr_d = retry_tmr_q - 10'd1;
					retry_fire  = (retry_tmr_q == 10'd1);
				end
				if (wait_act_q && wait_tmr_q != '0) begin
					wait_tmr_d = wait_tmr_q - 16'd1;
					wait_fire  = (wait_tmr_q == 16'd1);
				end
				if (state_q == ST_WAITING && (retry_fire || wait_fire)) begin
					if (retry_fire) begin
						if (retry_cnt_q != 8'hFF) begin
							retry_cnt_d = retry_cnt_q + 8'd1;
						end
						retry_tmr_d = '0;
						retry_act_d = 1'b0;
					end
					state_d    = ST_RUNNING;
					wait_tmr_d = '0;
					wait_act_d = 1'b0;
					notify_d   = 1'b1;
				end
			end
			OP_ARM: begin
				if (state_q != ST_RUNNING) begin
					fault_d = FLT_NOT_ALLOWED;
				end else if (wait_act_q) begin
					fault_d = FLT_WAIT_ARMED;
				end else begin
					wait_tmr_d = (item_s1.wait_ticks == '0) ? 16'd1 : item_s1.wait_ticks;
					wait_act_d = 1'b1;
				end
			end
			default: begin
				fault_d = FLT_NOT_ALLOWED;
			end
		endcase
	end

	// result view
	always_comb begin
		res_d.job_state    = retry_act_d ? ST_RETRYING : state_d;
		res_d.retry_number = retry_cnt_d;
		res_d.retry_eta    = retry_act_d ? retry_tmr_d : '0;
		res_d.notify       = notify_d;
		res_d.fault        = fault_d;
		unique case (state_d)
			ST_WAITING, ST_RETRYING: res_d.public_state = PS_WAITING;
			ST_SUCCESS:              res_d.public_state = PS_SUCCESS;
			ST_FAILURE:              res_d.public_state = PS_FAILURE;
			ST_ABORTED:              res_d.public_state = PS_ABORTED;
			default:                 res_d.public_state = PS_RUNNING;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_retries_q <= MAX_RETRIES_RST;
		end else if (cfg_we) begin
			max_retries_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_PENDING;
			retry_cnt_q <= '0;
			retry_tmr_q <= '0;
			retry_act_q <= 1'b0;
			wait_tmr_q  <= '0;
			wait_act_q  <= 1'b0;
		end else if (advance) begin
			state_q     <= state_d;
			retry_cnt_q <= retry_cnt_d;
			retry_tmr_q <= retry_tmr_d;
			retry_act_q <= retry_act_d;
			wait_tmr_q  <= wait_tmr_d;
			wait_act_q  <= wait_act_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res_d;
		end
	end

	a_no_held_retrying: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_RETRYING)
		else $error("held state is retrying");

	a_retry_eta_range: assert property (@(posedge clk) disable iff (!arst_n)
		retry_act_q |-> retry_tmr_q <= 10'd512)
		else $error("retry timer beyond backoff range");

	a_fault_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && fault_d != FLT_NONE |=>
			state_q == $past(state_q) && retry_cnt_q == $past(retry_cnt_q) &&
			retry_act_q == $past(retry_act_q) && wait_act_q == $past(wait_act_q))
		else $error("faulting command changed state");

	a_notify_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.notify |-> out_q.public_state == PS_RUNNING &&
			out_q.fault == FLT_NONE)
		else $error("notify without wake to running");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result lost after advance");

endmodule
